// File: rtl/core/multichannel_pwm_slew_shaper_assert.svh
// Assertion macros for the PWM slew shaper checks.
`ifndef MULTICHANNEL_PWM_SLEW_SHAPER_ASSERT_SVH
`define MULTICHANNEL_PWM_SLEW_SHAPER_ASSERT_SVH

// Check a same-cycle implication outside reset.
`define MPSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle outside reset.
`define MPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mpss_pkg.sv
// Shared widths, request types and constants of the PWM slew shaper.
package mpss_pkg;

    localparam int SET_W   = 61;
    localparam int DIV_W   = 44;
    localparam int DVS_W   = 16;
    localparam int RCP_W   = 32;
    localparam int RAD_W   = 61;
    localparam int ROOT_W  = 31;

    localparam int DEF_CHANNELS    = 4;
    localparam int DEF_MIX_CHANNEL = 0;
    localparam int DEF_FULL_SCALE  = 1023;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [RCP_W-1:0] recip;
    } t_div_req;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } t_sqrt_req;

    // log2 in Q16 by repeated squaring of a Q30 mantissa, truncating
    function automatic logic [19:0] log2_q16(input int unsigned v);
        int unsigned n;
        logic [63:0] m;
        logic [15:0] frac;
        n = 0;
        for (int i = 1; i < 32; i++) begin
            if ((v >> i) != 0) n = i;
        end
        m = 64'(v) << (30 - n);
        frac = '0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return {4'(n), frac};
    endfunction

    localparam logic [19:0] LOG2_TOP = log2_q16(1023);

endpackage

// File: rtl/core/mpss_div.sv
// Divider by a fixed divisor: reciprocal multiply per 16-bit digit, then one correction.
module mpss_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mpss_pkg::t_div_req          i_req,
    output logic [mpss_pkg::DIV_W-1:0]  o_quo,
    output logic                        o_done
);
    import mpss_pkg::*;

    localparam int DIG_W  = 16;
    localparam int NUM_W  = 48;
    localparam int DIGITS = NUM_W / DIG_W;
    localparam int CNT_W  = $clog2(DIGITS);

    localparam logic [1:0] P_EST  = 2'd0;
    localparam logic [1:0] P_BACK = 2'd1;
    localparam logic [1:0] P_FIX  = 2'd2;

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [RCP_W-1:0] r_rcp;
    logic [31:0]      r_t;
    logic [63:0]      r_est;
    logic [DIG_W-1:0] r_q0;
    logic [31:0]      r_qd;
    logic [1:0]       r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [31:0]      t_cur;
    logic [31:0]      diff;
    logic             fix;
    logic [DIG_W-1:0] q_dig;
    logic [31:0]      rem_new;

    // Partial remainder with the next dividend digit brought down
    assign t_cur = {r_rem, r_num[NUM_W-1 -: DIG_W]};

    // The estimate is low by at most one: correct it once
    assign diff    = r_t - r_qd;
    assign fix     = diff >= 32'(r_dvs);
    assign q_dig   = r_q0 + DIG_W'(fix);
    assign rem_new = fix ? diff - 32'(r_dvs) : diff;

    // Control: steps through the estimate, multiply-back and fix phases for each quotient digit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= P_EST;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= P_EST;
                r_cnt   <= '0;
            end else if (r_busy) begin
                unique case (r_phase)
                    P_EST:   r_phase <= P_BACK;
                    P_BACK:  r_phase <= P_FIX;
                    default: begin
                        r_phase <= P_EST;
                        r_cnt   <= r_cnt + 1'b1;
                        if (r_cnt == CNT_W'(DIGITS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Datapath: estimate digit, multiply back, correct and shift
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= NUM_W'(i_req.dividend);
            r_quo <= '0;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_rcp <= i_req.recip;
        end else if (r_busy) begin
            unique case (r_phase)
                P_EST: begin
                    r_t   <= t_cur;
                    r_est <= 64'(t_cur) * 64'(r_rcp);
                end
                P_BACK: begin
                    r_q0 <= r_est[47:32];
                    r_qd <= 32'(r_est[47:32]) * 32'(r_dvs);
                end
                default: begin
                    r_quo <= {r_quo[NUM_W-DIG_W-1:0], q_dig};
                    r_num <= {r_num[NUM_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    r_rem <= rem_new[DVS_W-1:0];
                end
            endcase
        end
    end

    assign o_quo  = r_quo[DIV_W-1:0];
    assign o_done = r_done;

endmodule

// File: rtl/core/mpss_isqrt.sv
// Integer square root, one result bit per cycle.
module mpss_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mpss_pkg::t_sqrt_req          i_req,
    output logic [mpss_pkg::ROOT_W-1:0]  o_root,
    output logic                         o_done
);
    import mpss_pkg::*;

    logic [RAD_W-1:0] r_x;
    logic [RAD_W:0]   r_res;
    logic [RAD_W-1:0] r_bit;
    logic             r_busy;
    logic             r_done;
    logic [RAD_W:0]   sum;
    logic             take;

    assign sum  = r_res + {1'b0, r_bit};
    assign take = {1'b0, r_x} >= sum;

    // Control: stop after the lowest bit pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: subtract trial square, shift root
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.radicand;
            r_res <= '0;
            r_bit <= {1'b1, {(RAD_W-1){1'b0}}};
        end else if (r_busy) begin
            if (take) begin
                r_x   <= RAD_W'({1'b0, r_x} - sum);
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[ROOT_W-1:0];
    assign o_done = r_done;

endmodule

// File: rtl/core/multichannel_pwm_slew_shaper.sv
// Per-channel PWM duty shaping: source select, gamma curve, window map, slew limit.
// Flow: a speed-scaling divide per tick, then per channel a gamma stage (a bypass divide,
// or 16 log squarings and 16 square roots, skipped for a zero level), a span divide and,
// when dynamic slew is on, a slew divide; a stalled result beat holds the channel.
// Throughput: one tick at a time, set by the shared multiplier, divider and square root.
// Reset (synchronous, active low) clears settings, stored duties and all control state.
module multichannel_pwm_slew_shaper #(
    parameter int CHANNELS    = mpss_pkg::DEF_CHANNELS,
    parameter int MIX_CHANNEL = mpss_pkg::DEF_MIX_CHANNEL,
    parameter int FULL_SCALE  = mpss_pkg::DEF_FULL_SCALE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [mpss_pkg::SET_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [15:0]                i_elapsed_ms,
    input  logic [9:0]                 i_mix_target,
    input  logic signed [15:0]         i_velocity,
    input  logic signed [15:0]         i_breath,
    input  logic                       i_contact,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_channel,
    output logic [9:0]                 o_duty,
    output logic                       o_changed,
    output logic                       o_last
);
    import mpss_pkg::*;

    localparam int SW = $clog2(FULL_SCALE + 1);

    localparam logic [RCP_W-1:0] RCP_SPEED = RCP_W'((64'd1 << 32) / 64'd1000);
    localparam logic [RCP_W-1:0] RCP_BYP   = RCP_W'((64'd1 << 32) / 64'd2046);
    localparam logic [RCP_W-1:0] RCP_SPAN  = RCP_W'((64'd1 << 32) / 64'(FULL_SCALE));
    localparam logic [RCP_W-1:0] RCP_DYN   = RCP_W'((64'd1 << 32) / 64'd100);

    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_MIX    = 2'd1;
    localparam logic [1:0] MODE_SPEED  = 2'd2;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SPD_GO    = 5'd1;
    localparam logic [4:0] S_SPD_WAIT  = 5'd2;
    localparam logic [4:0] S_LOAD      = 5'd3;
    localparam logic [4:0] S_BYP_MUL   = 5'd4;
    localparam logic [4:0] S_BYP_GO    = 5'd5;
    localparam logic [4:0] S_BYP_WAIT  = 5'd6;
    localparam logic [4:0] S_LOG_SQ    = 5'd7;
    localparam logic [4:0] S_LOG_ADJ   = 5'd8;
    localparam logic [4:0] S_EXP_MUL   = 5'd9;
    localparam logic [4:0] S_EXP_INIT  = 5'd10;
    localparam logic [4:0] S_EXP_GO    = 5'd11;
    localparam logic [4:0] S_EXP_WAIT  = 5'd12;
    localparam logic [4:0] S_EXP_SHIFT = 5'd13;
    localparam logic [4:0] S_SHP_MUL   = 5'd14;
    localparam logic [4:0] S_SHP_RND   = 5'd15;
    localparam logic [4:0] S_SPAN_MUL  = 5'd16;
    localparam logic [4:0] S_SPAN_GO   = 5'd17;
    localparam logic [4:0] S_SPAN_WAIT = 5'd18;
    localparam logic [4:0] S_SLEW_MUL  = 5'd19;
    localparam logic [4:0] S_DYN_MUL   = 5'd20;
    localparam logic [4:0] S_DYN_GO    = 5'd21;
    localparam logic [4:0] S_DYN_WAIT  = 5'd22;
    localparam logic [4:0] S_FIN       = 5'd23;

    logic [4:0]       r_state, n_state;
    logic [SET_W-1:0] r_set [4];
    logic [9:0]       r_duty [4];
    logic [1:0]       r_ch;

    // Captured tick
    logic [15:0] r_dt;
    logic [9:0]  r_mix;
    logic [9:0]  r_vsat;
    logic [9:0]  r_blvl;
    logic        r_contact;
    logic [9:0]  r_speed;

    // Shaping datapath
    logic [63:0]       r_prod;
    logic [30:0]       r_m;
    logic [15:0]       r_frac;
    logic [3:0]        r_n;
    logic [3:0]        r_k;
    logic [15:0]       r_fp;
    logic [7:0]        r_ip;
    logic [ROOT_W-1:0] r_r;
    logic [SW-1:0]     r_shaped;
    logic signed [19:0] r_target;

    // Output beat
    logic       r_o_valid;
    logic [1:0] r_o_channel;
    logic [9:0] r_o_duty;
    logic       r_o_changed;
    logic       r_o_last;

    // Shared units
    t_div_req          div_req;
    logic [DIV_W-1:0]  div_quo;
    logic              div_done;
    t_sqrt_req         sqrt_req;
    logic [ROOT_W-1:0] sqrt_root;
    logic              sqrt_done;

    mpss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    mpss_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_root  (sqrt_root),
        .o_done  (sqrt_done)
    );

    // Decode the input beat
    logic [16:0] vmag;
    logic [9:0]  vsat_in;
    logic [15:0] bsh;
    logic [26:0] bprod;
    assign vmag    = i_velocity[15] ? 17'h10000 - {1'b0, i_velocity} : {1'b0, i_velocity};
    assign vsat_in = (vmag > 17'd1000) ? 10'd1000 : vmag[9:0];
    assign bsh     = i_breath ^ 16'h8000;
    assign bprod   = {1'b0, bsh, 10'b0} - {11'b0, bsh} + 27'd32768;

    // Decode the current channel's settings
    logic [SET_W-1:0] cs;
    logic [1:0]  mode;
    logic [9:0]  manual, mn, mx;
    logic [15:0] slew;
    logic        dyn;
    logic [11:0] gamma;
    logic        snap;
    logic [9:0]  level;
    logic [3:0]  lvl_msb;
    assign cs     = r_set[r_ch];
    assign mode   = cs[1:0];
    assign manual = cs[11:2];
    assign mn     = cs[21:12];
    assign mx     = cs[31:22];
    assign slew   = cs[47:32];
    assign dyn    = cs[48];
    assign gamma  = cs[60:49];
    assign snap   = (r_ch == 2'(MIX_CHANNEL)) && r_contact && (mode == MODE_MIX);

    always_comb begin
        if (snap) begin
            level = 10'd1023;
        end else begin
            case (mode)
                MODE_MANUAL: level = manual;
                MODE_MIX:    level = r_mix;
                MODE_SPEED:  level = r_speed;
                default:     level = r_blvl;
            endcase
        end
        lvl_msb = '0;
        for (int i = 1; i < 10; i++) begin
            if (level[i]) lvl_msb = 4'(i);
        end
    end

    // Window span and log difference
    logic signed [10:0] span;
    logic [9:0]         aspan;
    logic [19:0]        lg, dlog;
    assign span  = $signed({1'b0, mx}) - $signed({1'b0, mn});
    assign aspan = span[10] ? 10'(-span) : span[9:0];
    assign lg    = {r_n, r_frac};
    assign dlog  = (lg > LOG2_TOP) ? 20'd0 : LOG2_TOP - lg;

    // Shared multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic        mul_en;
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (r_state)
            S_BYP_MUL:  begin mul_a = 32'(level);    mul_b = 32'(FULL_SCALE); end
            S_LOG_SQ:   begin mul_a = 32'(r_m);      mul_b = 32'(r_m);        end
            S_EXP_MUL:  begin mul_a = 32'(dlog);     mul_b = 32'(gamma);      end
            S_SHP_MUL:  begin mul_a = 32'(r_r);      mul_b = 32'(FULL_SCALE); end
            S_SPAN_MUL: begin mul_a = 32'(r_shaped); mul_b = 32'(aspan);      end
            S_SLEW_MUL: begin mul_a = 32'(slew);     mul_b = 32'(r_dt);       end
            S_DYN_MUL:  begin mul_a = r_prod[31:0];  mul_b = 32'(r_vsat) + 32'd100; end
            default:    mul_en = 1'b0;
        endcase
    end

    // Divider and square-root requests
    logic [30:0] exp_in;
    assign exp_in = r_fp[r_k] ? (r_r >> 1) : r_r;

    always_comb begin
        div_req  = '0;
        sqrt_req = '0;
        unique case (r_state)
            S_SPD_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({r_vsat, 10'b0} - {10'b0, r_vsat} + 20'd500);
                div_req.divisor  = DVS_W'(1000);
                div_req.recip    = RCP_SPEED;
            end
            S_BYP_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({r_prod[30:0], 1'b0} + 32'd1023);
                div_req.divisor  = DVS_W'(2046);
                div_req.recip    = RCP_BYP;
            end
            S_SPAN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({r_prod[31:0], 8'b0});
                div_req.divisor  = DVS_W'(FULL_SCALE);
                div_req.recip    = RCP_SPAN;
            end
            S_DYN_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod[DIV_W-1:0];
                div_req.divisor  = DVS_W'(100);
                div_req.recip    = RCP_DYN;
            end
            S_EXP_GO: begin
                sqrt_req.start    = 1'b1;
                sqrt_req.radicand = {exp_in, 30'b0};
            end
            default: ;
        endcase
    end

    // Slew limit and window clamp
    logic signed [39:0] tgt40, cur40, mc40, step, lim, mnq, mxq;
    logic [37:0]        mc;
    logic [9:0]         duty;
    logic               out_free;
    always_comb begin
        mc    = dyn ? div_quo[37:0] : 38'(r_prod[31:0]);
        tgt40 = 40'(r_target);
        cur40 = $signed({22'b0, r_duty[r_ch], 8'b0});
        mc40  = $signed({2'b0, mc});
        mnq   = $signed({22'b0, mn, 8'b0});
        mxq   = $signed({22'b0, mx, 8'b0});
        if (snap) begin
            step = tgt40;
            lim  = tgt40;
        end else if (tgt40 > cur40) begin
            step = cur40 + mc40;
            lim  = (step < tgt40) ? step : tgt40;
        end else begin
            step = cur40 - mc40;
            lim  = (step > tgt40) ? step : tgt40;
        end
        if (lim < mnq)      duty = mn;
        else if (lim > mxq) duty = mx;
        else                duty = lim[17:8];
    end
    assign out_free = !r_o_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_SPD_GO;
            S_SPD_GO:    n_state = S_SPD_WAIT;
            S_SPD_WAIT:  if (div_done) n_state = S_LOAD;
            S_LOAD: begin
                if (gamma == 12'd256)   n_state = S_BYP_MUL;
                else if (level == '0)   n_state = S_SPAN_MUL;
                else                    n_state = S_LOG_SQ;
            end
            S_BYP_MUL:   n_state = S_BYP_GO;
            S_BYP_GO:    n_state = S_BYP_WAIT;
            S_BYP_WAIT:  if (div_done) n_state = S_SPAN_MUL;
            S_LOG_SQ:    n_state = S_LOG_ADJ;
            S_LOG_ADJ:   n_state = (r_k == 4'd15) ? S_EXP_MUL : S_LOG_SQ;
            S_EXP_MUL:   n_state = S_EXP_INIT;
            S_EXP_INIT:  n_state = (r_prod[31:24] >= 8'd31) ? S_SHP_MUL : S_EXP_GO;
            S_EXP_GO:    n_state = S_EXP_WAIT;
            S_EXP_WAIT: begin
                if (sqrt_done) n_state = (r_k == 4'd15) ? S_EXP_SHIFT : S_EXP_GO;
            end
            S_EXP_SHIFT: n_state = S_SHP_MUL;
            S_SHP_MUL:   n_state = S_SHP_RND;
            S_SHP_RND:   n_state = S_SPAN_MUL;
            S_SPAN_MUL:  n_state = S_SPAN_GO;
            S_SPAN_GO:   n_state = S_SPAN_WAIT;
            S_SPAN_WAIT: if (div_done) n_state = snap ? S_FIN : S_SLEW_MUL;
            S_SLEW_MUL:  n_state = dyn ? S_DYN_MUL : S_FIN;
            S_DYN_MUL:   n_state = S_DYN_GO;
            S_DYN_GO:    n_state = S_DYN_WAIT;
            S_DYN_WAIT:  if (div_done) n_state = S_FIN;
            S_FIN: begin
                if (out_free) n_state = (r_ch == 2'(CHANNELS - 1)) ? S_IDLE : S_LOAD;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Control state, settings and stored duties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ch      <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_set[i]  <= '0;
                r_duty[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_set[i_cfg_index] <= i_cfg_data;
            if (r_state == S_FIN && out_free) begin
                r_o_valid    <= 1'b1;
                r_duty[r_ch] <= duty;
                r_ch         <= (r_ch == 2'(CHANNELS - 1)) ? 2'd0 : r_ch + 2'd1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= 64'(mul_a) * 64'(mul_b);
        unique case (r_state)
            S_IDLE: begin
                r_dt      <= (i_elapsed_ms == '0) ? 16'd1 : i_elapsed_ms;
                r_mix     <= i_mix_target;
                r_vsat    <= vsat_in;
                r_blvl    <= bprod[25:16];
                r_contact <= i_contact;
            end
            S_SPD_WAIT: r_speed <= div_quo[9:0];
            S_LOAD: begin
                r_shaped <= (gamma == '0) ? SW'(FULL_SCALE) : '0;
                r_n      <= lvl_msb;
                r_m      <= 31'(level) << (5'd30 - 5'(lvl_msb));
                r_frac   <= '0;
                r_k      <= '0;
            end
            S_BYP_WAIT: r_shaped <= div_quo[SW-1:0];
            S_LOG_ADJ: begin
                r_frac <= {r_frac[14:0], r_prod[61]};
                r_m    <= r_prod[61] ? r_prod[61:31] : r_prod[60:30];
                r_k    <= r_k + 4'd1;
            end
            S_EXP_INIT: begin
                r_fp <= r_prod[23:8];
                r_ip <= r_prod[31:24];
                r_k  <= '0;
                r_r  <= (r_prod[31:24] >= 8'd31) ? '0 : ROOT_W'(1) << 30;
            end
            S_EXP_WAIT: begin
                if (sqrt_done) begin
                    r_r <= sqrt_root;
                    r_k <= r_k + 4'd1;
                end
            end
            S_EXP_SHIFT: r_r <= r_r >> r_ip[4:0];
            S_SHP_RND:   r_shaped <= SW'((r_prod + 64'h2000_0000) >> 30);
            S_SPAN_WAIT: begin
                r_target <= span[10]
                    ? $signed({2'b0, mn, 8'b0}) - $signed({2'b0, div_quo[17:0]})
                    : $signed({2'b0, mn, 8'b0}) + $signed({2'b0, div_quo[17:0]});
            end
            S_FIN: begin
                if (out_free) begin
                    r_o_channel <= r_ch;
                    r_o_duty    <= duty;
                    r_o_changed <= duty != r_duty[r_ch];
                    r_o_last    <= r_ch == 2'(CHANNELS - 1);
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_o_valid;
    assign o_channel   = r_o_channel;
    assign o_duty      = r_o_duty;
    assign o_changed   = r_o_changed;
    assign o_last      = r_o_last;

`include "multichannel_pwm_slew_shaper_assert.svh"

    `MPSS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "tick accepted but block not busy")
    `MPSS_ASSERT_NOW(a_duty_stored, r_o_valid, r_o_duty == r_duty[r_o_channel], "pending duty not stored")
    `MPSS_ASSERT_NOW(a_last_channel, r_o_valid && r_o_last, r_o_channel == 2'(CHANNELS - 1), "last beat on wrong channel")

endmodule

// File: test/multichannel_pwm_slew_shaper_check.sv
// Duty predictor and result checker for the PWM slew shaper testbench.
`timescale 1ns / 1ps

package pwm_shaper_tb_pkg;
    typedef enum logic [1:0] {
        SRC_MANUAL = 2'd0,
        SRC_MIX    = 2'd1,
        SRC_SPEED  = 2'd2,
        SRC_BREATH = 2'd3
    } t_src_mode;

    localparam logic [11:0] GAMMA_UNITY = 12'd256;
endpackage

module multichannel_pwm_slew_shaper_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [mpss_pkg::SET_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [15:0]                i_elapsed_ms,
    input  logic [9:0]                 i_mix_target,
    input  logic signed [15:0]         i_velocity,
    input  logic signed [15:0]         i_breath,
    input  logic                       i_contact,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [1:0]                 i_channel,
    input  logic [9:0]                 i_duty,
    input  logic                       i_changed,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_pending
);
    import pwm_shaper_tb_pkg::*;

    localparam int          NCH   = mpss_pkg::DEF_CHANNELS;
    localparam int          MIXCH = mpss_pkg::DEF_MIX_CHANNEL;
    localparam longint      FS    = mpss_pkg::DEF_FULL_SCALE;
    localparam bit [63:0]   ONE30 = 64'd1 << 30;

    typedef struct {
        logic [1:0] channel;
        logic [9:0] duty;
        logic       changed;
        logic       last;
    } t_duty_beat;

    logic [60:0] chan_cfg [4];
    logic [9:0]  held_duty [4];
    t_duty_beat  duty_expect_q [$];

    assign o_pending = duty_expect_q.size();

    function automatic bit [63:0] int_sqrt(input bit [63:0] x);
        bit [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 in Q16 via repeated squaring of a Q30 mantissa
    function automatic longint log2_fix(input int unsigned v);
        int unsigned n;
        bit [63:0]   m;
        longint      frac;
        n = 0;
        frac = 0;
        while (n < 31 && (v >> (n + 1)) != 0) n++;
        m = 64'(v) << (30 - n);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (ONE30 << 1)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(n) << 16) | frac;
    endfunction

    // 2^-e in Q30 with e in Q16
    function automatic bit [63:0] pow2_neg(input bit [63:0] e);
        bit [63:0] ip, fp, r;
        ip = e >> 16;
        fp = e & 64'hFFFF;
        r = ONE30;
        if (ip >= 31) return 0;
        for (int k = 0; k < 16; k++) begin
            if ((fp >> k) & 1) r = r >> 1;
            r = int_sqrt(r << 30);
        end
        return r >> ip;
    endfunction

    function automatic longint gamma_shape(input int unsigned level, input int unsigned g);
        longint    d;
        bit [63:0] r;
        if (g == GAMMA_UNITY) return (longint'(level) * FS * 2 + 1023) / 2046;
        if (level == 0) return (g == 0) ? FS : 0;
        d = log2_fix(1023) - log2_fix(level);
        if (d < 0) d = 0;
        r = pow2_neg((64'(d) * g) >> 8);
        return longint'((r * 64'(FS) + (64'd1 << 29)) >> 30);
    endfunction

    // Work out every channel's duty for one tick and advance the stored duties
    function automatic void predict_tick(input logic [15:0] ems, input logic [9:0] mix,
                                         input logic signed [15:0] vel,
                                         input logic signed [15:0] brth, input logic cont);
        longint      dt, vmag, vsat, speed_lvl, breath_lvl;
        longint      mn, mx, slew, span, shaped, prod, target, cur, mc, lim;
        int unsigned level, g;
        t_src_mode   mode;
        logic [60:0] s;
        bit          dyn, snap;
        logic [9:0]  duty;
        t_duty_beat  beat;
        dt = (ems == 0) ? 1 : longint'(ems);
        vmag = (vel < 0) ? -longint'(vel) : longint'(vel);
        vsat = (vmag > 1000) ? 1000 : vmag;
        speed_lvl = (vsat * 1023 + 500) / 1000;
        breath_lvl = ((longint'(brth) + 32768) * 1023 + 32768) >> 16;
        for (int ch = 0; ch < NCH; ch++) begin
            s = chan_cfg[ch];
            mode = t_src_mode'(s[1:0]);
            mn = s[21:12];
            mx = s[31:22];
            slew = s[47:32];
            dyn = s[48];
            g = s[60:49];
            snap = (ch == MIXCH) && cont && (mode == SRC_MIX);
            if (snap) level = 1023;
            else case (mode)
                SRC_MANUAL: level = s[11:2];
                SRC_MIX:    level = mix;
                SRC_SPEED:  level = speed_lvl;
                default:    level = breath_lvl;
            endcase
            shaped = gamma_shape(level, g);
            span = mx - mn;
            prod = shaped * ((span < 0) ? -span : span) * 256 / FS;
            target = mn * 256 + ((span < 0) ? -prod : prod);
            cur = longint'(held_duty[ch]) * 256;
            if (snap) begin
                lim = target;
            end else begin
                mc = slew * dt;
                if (dyn) mc = mc * (100 + vsat) / 100;
                if (target > cur) lim = (cur + mc < target) ? cur + mc : target;
                else lim = (cur - mc > target) ? cur - mc : target;
            end
            if (lim < mn * 256) duty = mn[9:0];
            else if (lim > mx * 256) duty = mx[9:0];
            else duty = 10'(lim >> 8);
            beat.channel = ch[1:0];
            beat.duty = duty;
            beat.changed = (duty != held_duty[ch]);
            beat.last = (ch == NCH - 1);
            duty_expect_q.push_back(beat);
            held_duty[ch] = duty;
        end
    endfunction

    // Track config, predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_duty_beat exp_beat;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                chan_cfg[i] = '0;
                held_duty[i] = '0;
            end
            duty_expect_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) chan_cfg[i_cfg_index] = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                predict_tick(i_elapsed_ms, i_mix_target, i_velocity, i_breath, i_contact);
            if (i_out_valid && !i_out_stall) begin
                if (duty_expect_q.size() == 0) begin
                    $error("result beat with nothing expected: channel %0d duty %0d",
                           i_channel, i_duty);
                    o_fail_count++;
                end else begin
                    exp_beat = duty_expect_q.pop_front();
                    if (i_channel !== exp_beat.channel) begin
                        $error("channel: expected %0d, got %0d", exp_beat.channel, i_channel);
                        o_fail_count++;
                    end
                    if (i_duty !== exp_beat.duty) begin
                        $error("duty: expected %0d, got %0d", exp_beat.duty, i_duty);
                        o_fail_count++;
                    end
                    if (i_changed !== exp_beat.changed) begin
                        $error("changed: expected %0b, got %0b", exp_beat.changed, i_changed);
                        o_fail_count++;
                    end
                    if (i_last !== exp_beat.last) begin
                        $error("last: expected %0b, got %0b", exp_beat.last, i_last);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

// File: test/multichannel_pwm_slew_shaper_test.sv
// Stimulus and verdict for the PWM slew shaper testbench.
`timescale 1ns / 1ps

module multichannel_pwm_slew_shaper_test;
    import pwm_shaper_tb_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [1:0]                 i_cfg_index;
    logic [mpss_pkg::SET_W-1:0] i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [15:0]                i_elapsed_ms;
    logic [9:0]                 i_mix_target;
    logic signed [15:0]         i_velocity;
    logic signed [15:0]         i_breath;
    logic                       i_contact;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [1:0]                 o_channel;
    logic [9:0]                 o_duty;
    logic                       o_changed;
    logic                       o_last;
    int                         fail_count;
    int                         pending;
    int                         cycle_count;
    bit                         calm;
    bit                         hold_req;

    multichannel_pwm_slew_shaper dut (.*);

    multichannel_pwm_slew_shaper_check checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_elapsed_ms, .i_mix_target,
        .i_velocity, .i_breath, .i_contact,
        .i_out_valid(o_out_valid), .i_out_stall, .i_channel(o_channel),
        .i_duty(o_duty), .i_changed(o_changed), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall per beat, one long hold-off on request
    initial begin
        int w;
        i_out_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (6000) @(negedge i_clk);
                hold_req = 1'b0;
            end
            w = calm ? 0 : $urandom_range(0, 10);
            if (w > 0) begin
                i_out_stall = 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic logic [60:0] pack_cfg(input t_src_mode mode, input logic [9:0] manual,
                                             input logic [9:0] mn, input logic [9:0] mx,
                                             input logic [15:0] slew, input logic dyn,
                                             input logic [11:0] g);
        return {g, dyn, slew, mx, mn, manual, mode};
    endfunction

    function automatic logic [60:0] rand_cfg();
        logic [15:0] slew;
        logic [11:0] g;
        slew = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 600)) : 16'($urandom);
        g = ($urandom_range(0, 3) == 0) ? 12'($urandom) : GAMMA_UNITY;
        return pack_cfg(t_src_mode'($urandom_range(0, 3)), 10'($urandom), 10'($urandom),
                        10'($urandom), slew, 1'($urandom), g);
    endfunction

    task automatic write_cfg(input logic [1:0] idx, input logic [60:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_tick(input logic [15:0] ems, input logic [9:0] mix,
                             input logic [15:0] vel, input logic [15:0] brth,
                             input logic cont);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_elapsed_ms = ems;
        i_mix_target = mix;
        i_velocity = vel;
        i_breath = brth;
        i_contact = cont;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_random_tick();
        logic [15:0] ems, vel;
        ems = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        vel = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 2400)) - 1200);
        send_tick(ems, 10'($urandom), vel, 16'($urandom), 1'($urandom));
    endtask

    // Drop valid and wait for every expected beat
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        cycle_count = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_elapsed_ms = '0;
        i_mix_target = '0;
        i_velocity = '0;
        i_breath = '0;
        i_contact = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: gamma zero on level zero everywhere
        send_tick(16'd0, 10'd0, 16'd0, 16'h8000, 1'b0);
        drain();

        // Directed: snap on mix, inverted window, dynamic speed, breath curve
        write_cfg(2'd0, pack_cfg(SRC_MIX, 10'd0, 10'd100, 10'd900, 16'd256, 1'b0, GAMMA_UNITY));
        write_cfg(2'd1, pack_cfg(SRC_MANUAL, 10'd1023, 10'd800, 10'd200, 16'd1, 1'b0,
                                 GAMMA_UNITY));
        write_cfg(2'd2, pack_cfg(SRC_SPEED, 10'd0, 10'd0, 10'd1023, 16'd3, 1'b1, 12'd512));
        write_cfg(2'd3, pack_cfg(SRC_BREATH, 10'd0, 10'd0, 10'd1023, 16'hFFFF, 1'b0, 12'd0));
        send_tick(16'd0, 10'd0, 16'h8000, 16'h8000, 1'b0);
        send_tick(16'hFFFF, 10'd1023, 16'h7FFF, 16'h7FFF, 1'b0);
        send_tick(16'd1, 10'd512, 16'd1000, 16'd0, 1'b1);
        send_tick(16'd5, 10'd0, -16'sd1001, 16'h8001, 1'b1);
        send_tick(16'd2, 10'd1, 16'd0, 16'h4000, 1'b0);
        send_tick(16'd3, 10'd1023, 16'd999, 16'hC000, 1'b1);
        send_tick(16'd0, 10'd300, -16'sd1, 16'h0001, 1'b0);
        drain();
        write_cfg(2'd0, pack_cfg(SRC_MANUAL, 10'd5, 10'd300, 10'd600, 16'd0, 1'b1, 12'd4095));
        write_cfg(2'd1, pack_cfg(SRC_MIX, 10'd0, 10'd1023, 10'd0, 16'd40, 1'b1, GAMMA_UNITY));
        write_cfg(2'd2, pack_cfg(SRC_BREATH, 10'd0, 10'd50, 10'd50, 16'd10, 1'b0, 12'd128));
        write_cfg(2'd3, pack_cfg(SRC_SPEED, 10'd0, 10'd1023, 10'd1023, 16'd1, 1'b1, 12'd0));
        send_tick(16'd1, 10'd1023, 16'd0, 16'h8000, 1'b1);
        send_tick(16'd7, 10'd0, 16'd20000, 16'h7FFF, 1'b1);
        send_tick(16'd100, 10'd700, -16'sd500, 16'd0, 1'b0);
        send_tick(16'd0, 10'd1023, 16'd1, 16'h1234, 1'b0);
        drain();

        // Random phases with fresh settings each time
        for (int ph = 0; ph < 5; ph++) begin
            for (int c = 0; c < 4; c++) write_cfg(c[1:0], rand_cfg());
            if (ph == 3) begin
                write_cfg(2'd0, {61{1'b1}});
                write_cfg(2'd3, '0);
            end
            calm = (ph == 1);
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < 44; n++) send_random_tick();
            drain();
        end

        calm = 1'b0;
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3000) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
